>>> design/spfdo_pkg.sv
// Shared types and constants for the stereo pair ring buffer.
// Used by the sequencer, the output pipeline and the core through scoped names.
`default_nettype none
package spfdo_pkg;

    localparam int RING_DEPTH = 256;
    localparam int MAX_TAKE   = 64;
    localparam int ADDR_W     = $clog2(RING_DEPTH);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int FILL_W     = 9;
    localparam int TAKE_W     = 7;
    localparam int SAMPLE_W   = 16;
    localparam int PAIR_W     = 2 * SAMPLE_W;
    localparam int WORD_W     = 32;
    localparam int KIND_W     = 2;

    localparam logic [KIND_W-1:0] KIND_RAW   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TAKE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FLUSH = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_ISSUE
    } ctrl_state_t;

    // One result request from the sequencer to the output pipeline.
    typedef struct packed {
        logic              valid;
        logic              pair;
        logic [FILL_W-1:0] fill;
        logic              last;
    } issue_t;

endpackage
`default_nettype wire

>>> design/spfdo_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Standalone; no package dependency.
`default_nettype none
module spfdo_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 8
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

>>> design/spfdo_ctrl.sv
// Sequencer: pairs channel words, keeps the ring counters, drives the RAM ports
// and issues result requests. Depends on spfdo_pkg.
`default_nettype none
module spfdo_ctrl (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [spfdo_pkg::KIND_W-1:0]      in_kind,
    input  wire logic [spfdo_pkg::WORD_W-1:0]      in_word,
    input  wire logic [spfdo_pkg::TAKE_W-1:0]      in_take,
    input  wire logic                              can_issue,
    output spfdo_pkg::issue_t                      iss,
    output logic                                   ram_we,
    output logic [spfdo_pkg::ADDR_W-1:0]           ram_waddr,
    output logic [spfdo_pkg::PAIR_W-1:0]           ram_wdata,
    output logic                                   ram_re,
    output logic [spfdo_pkg::ADDR_W-1:0]           ram_raddr
);

    spfdo_pkg::ctrl_state_t state_reg, state_next;

    logic [spfdo_pkg::CNT_W-1:0]    wr_reg, wr_next;
    logic [spfdo_pkg::CNT_W-1:0]    rd_reg, rd_next;
    logic [spfdo_pkg::SAMPLE_W-1:0] held_reg, held_next;
    logic                           lw_reg, lw_next;
    logic [spfdo_pkg::TAKE_W-1:0]   rem_reg, rem_next;
    logic                           pair_mode_reg, pair_mode_next;
    logic [spfdo_pkg::CNT_W-1:0]    nop_fill_reg, nop_fill_next;

    logic                           accept;
    logic [spfdo_pkg::CNT_W-1:0]    fill_now;
    logic [spfdo_pkg::CNT_W-1:0]    fill_after;
    logic [spfdo_pkg::TAKE_W-1:0]   take_sat;
    logic [spfdo_pkg::SAMPLE_W-1:0] sample;
    logic                           issue_fire;
    logic                           issue_last;

    assign accept     = in_valid && in_ready;
    assign fill_now   = wr_reg - rd_reg;
    assign fill_after = fill_now - spfdo_pkg::CNT_W'(1);
    assign sample     = in_word[spfdo_pkg::WORD_W-1 -: spfdo_pkg::SAMPLE_W];
    assign take_sat   = (in_take > spfdo_pkg::TAKE_W'(spfdo_pkg::MAX_TAKE))
                      ? spfdo_pkg::TAKE_W'(spfdo_pkg::MAX_TAKE) : in_take;
    assign issue_fire = (state_reg == spfdo_pkg::ST_ISSUE) && can_issue;
    assign issue_last = !pair_mode_reg || (rem_reg == spfdo_pkg::TAKE_W'(1))
                      || (fill_after == '0);

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            spfdo_pkg::ST_IDLE: begin
                if (accept && (in_kind == spfdo_pkg::KIND_TAKE ||
                               in_kind == spfdo_pkg::KIND_FLUSH)) begin
                    state_next = spfdo_pkg::ST_ISSUE;
                end
            end
            spfdo_pkg::ST_ISSUE: begin
                if (issue_fire && issue_last) begin
                    state_next = spfdo_pkg::ST_IDLE;
                end
            end
            default: state_next = spfdo_pkg::ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        in_ready  = (state_reg == spfdo_pkg::ST_IDLE);
        iss.valid = (state_reg == spfdo_pkg::ST_ISSUE);
        iss.pair  = pair_mode_reg;
        iss.fill  = pair_mode_reg ? spfdo_pkg::FILL_W'(fill_after)
                                  : spfdo_pkg::FILL_W'(nop_fill_reg);
        iss.last  = issue_last;
        ram_re    = issue_fire && pair_mode_reg;
        ram_raddr = rd_reg[spfdo_pkg::ADDR_W-1:0];
        ram_waddr = wr_reg[spfdo_pkg::ADDR_W-1:0];
        ram_wdata = {held_reg, in_word[spfdo_pkg::WORD_W-1 -: spfdo_pkg::SAMPLE_W]};
        ram_we    = accept && (in_kind == spfdo_pkg::KIND_RAW) && in_word[0] && lw_reg;
    end

    // Datapath next values.
    always_comb begin
        wr_next        = wr_reg;
        rd_next        = rd_reg;
        held_next      = held_reg;
        lw_next        = lw_reg;
        rem_next       = rem_reg;
        pair_mode_next = pair_mode_reg;
        nop_fill_next  = nop_fill_reg;
        if (accept) begin
            case (in_kind)
                spfdo_pkg::KIND_RAW: begin
                    if (!in_word[0]) begin
                        held_next = sample;
                        lw_next   = 1'b1;
                    end else if (lw_reg) begin
                        lw_next = 1'b0;
                        wr_next = wr_reg + spfdo_pkg::CNT_W'(1);
                        // A full ring loses its oldest pair.
                        if (fill_now >= spfdo_pkg::CNT_W'(spfdo_pkg::RING_DEPTH)) begin
                            rd_next = rd_reg + spfdo_pkg::CNT_W'(1);
                        end
                    end
                end
                spfdo_pkg::KIND_TAKE: begin
                    rem_next      = take_sat;
                    nop_fill_next = fill_now;
                    pair_mode_next = (take_sat != '0) && (fill_now != '0);
                end
                spfdo_pkg::KIND_FLUSH: begin
                    rd_next        = wr_reg;
                    lw_next        = 1'b0;
                    pair_mode_next = 1'b0;
                    nop_fill_next  = '0;
                end
                default: begin
                end
            endcase
        end else if (issue_fire && pair_mode_reg) begin
            rd_next  = rd_reg + spfdo_pkg::CNT_W'(1);
            rem_next = rem_reg - spfdo_pkg::TAKE_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= spfdo_pkg::ST_IDLE;
            wr_reg        <= '0;
            rd_reg        <= '0;
            held_reg      <= '0;
            lw_reg        <= 1'b0;
            pair_mode_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            wr_reg        <= wr_next;
            rd_reg        <= rd_next;
            held_reg      <= held_next;
            lw_reg        <= lw_next;
            pair_mode_reg <= pair_mode_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg      <= rem_next;
        nop_fill_reg <= nop_fill_next;
    end

endmodule
`default_nettype wire

>>> design/spfdo_out.sv
// Two-stage result pipeline: the RAM read stage and the output register.
// Depends on spfdo_pkg.
`default_nettype none
module spfdo_out (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire spfdo_pkg::issue_t             iss,
    output logic                               can_issue,
    input  wire logic [spfdo_pkg::PAIR_W-1:0]  ram_q,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [47:0]                        m_axis_tdata,
    output logic                               m_axis_tuser,
    output logic                               m_axis_tlast
);

    logic                          s1_valid_reg;
    logic                          s1_pair_reg;
    logic [spfdo_pkg::FILL_W-1:0]  s1_fill_reg;
    logic                          s1_last_reg;

    logic                          m_valid_reg;
    logic [spfdo_pkg::PAIR_W-1:0]  m_pair_reg;
    logic [spfdo_pkg::FILL_W-1:0]  m_fill_reg;
    logic                          m_user_reg;
    logic                          m_last_reg;

    logic                          s2_load;

    assign s2_load   = s1_valid_reg && (!m_valid_reg || m_axis_tready);
    assign can_issue = !s1_valid_reg || s2_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (can_issue) begin
                s1_valid_reg <= iss.valid;
            end
            if (s2_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (can_issue && iss.valid) begin
            s1_pair_reg <= iss.pair;
            s1_fill_reg <= iss.fill;
            s1_last_reg <= iss.last;
        end
        if (s2_load) begin
            m_pair_reg <= s1_pair_reg ? ram_q : '0;
            m_fill_reg <= s1_fill_reg;
            m_user_reg <= s1_pair_reg;
            m_last_reg <= s1_last_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    // Low half of the pair word is the right sample, high half the left.
    assign m_axis_tdata  = {7'd0, m_fill_reg, m_pair_reg[spfdo_pkg::SAMPLE_W-1:0],
                            m_pair_reg[spfdo_pkg::PAIR_W-1 -: spfdo_pkg::SAMPLE_W]};
    assign m_axis_tuser  = m_user_reg;
    assign m_axis_tlast  = m_last_reg;

endmodule
`default_nettype wire

>>> design/stereo_pair_fifo_drop_oldest_core.sv
// Stereo pair ring buffer: pairs left/right receive words into a 256-pair ring.
// Results: a take or flush passes through the issue state, the RAM read stage and
// the output register; a take then returns one pair per cycle while the output is taken.
// The input is held off while a take or flush issues its results, paced by the
// single RAM read port and the two-stage output pipeline.
// Reset (aresetn low, synchronous) clears the counters and the held left sample; the
// RAM is not cleared since only written slots are ever read.
`default_nettype none
module stereo_pair_fifo_drop_oldest_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input channel.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata, from bit 0: raw_word[31:0], take_count[38:32], zero fill [39].
    input  wire logic [39:0] s_axis_tdata,
    // tuser: kind[1:0] (0 raw word, 1 take, 2 flush).
    input  wire logic [1:0]  s_axis_tuser,
    // Result channel.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata, from bit 0: left_sample[15:0], right_sample[31:16],
    // fill_level[40:32], zero fill [47:41].
    output logic [47:0]      m_axis_tdata,
    // tuser: pair_valid.
    output logic             m_axis_tuser,
    // tlast: final result of the take or flush transfer.
    output logic             m_axis_tlast
);

    spfdo_pkg::issue_t              iss;
    logic                           can_issue;
    logic                           ram_we;
    logic [spfdo_pkg::ADDR_W-1:0]   ram_waddr;
    logic [spfdo_pkg::PAIR_W-1:0]   ram_wdata;
    logic                           ram_re;
    logic [spfdo_pkg::ADDR_W-1:0]   ram_raddr;
    logic [spfdo_pkg::PAIR_W-1:0]   ram_q;

    // The sequencer owns the ring counters and the left-sample holding register.
    // Writes happen only on raw word transfers and reads only while a take is being
    // issued, so the two RAM ports never touch the same slot in one cycle.
    spfdo_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_kind   (s_axis_tuser),
        .in_word   (s_axis_tdata[31:0]),
        .in_take   (s_axis_tdata[38:32]),
        .can_issue (can_issue),
        .iss       (iss),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr)
    );

    // Pair store: left sample in the upper half, right in the lower half.
    spfdo_ram #(
        .DATA_W (spfdo_pkg::PAIR_W),
        .ADDR_W (spfdo_pkg::ADDR_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    // The RAM read register acts as the first pipeline stage; the output register
    // decouples the result channel so a stalled consumer only pauses issuing.
    spfdo_out u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .iss           (iss),
        .can_issue     (can_issue),
        .ram_q         (ram_q),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // A result without a pair always ends its transfer's results.
    a_nopair_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast)
        else $error("result without a pair is not marked last");

    // A result without a pair carries zero samples.
    a_nopair_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[31:0] == 32'd0))
        else $error("result without a pair carries nonzero samples");

    // The reported fill level never exceeds the ring depth.
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[40:32] <= spfdo_pkg::RING_DEPTH))
        else $error("fill level above ring depth");

    // No new item is taken while the sequencer is still issuing results.
    a_no_accept_issue: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == spfdo_pkg::KIND_TAKE)
        |=> !s_axis_tready)
        else $error("input accepted while a take is in progress");

endmodule
`default_nettype wire
